/* hdl/nlp_pkg.sv */
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants for the IPv4 prefix list parser.
// ----------------------------------------------------------------------------
package nlp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned LenW     = 6;
  localparam int unsigned LeftW    = 3;
  localparam int unsigned StatusW  = 2;

  localparam logic [ByteW-1:0] MaxPrefixBits = 8'd32;
  localparam logic [ByteW:0]   RoundUpBits   = 9'd7;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_LENGTH = 2'd1,
    STATUS_LEFTOVER   = 2'd2
  } status_t;

  typedef struct packed {
    logic             awaiting_length;
    logic [LenW-1:0]  held_length;
    logic [LeftW-1:0] bytes_left;
    logic [AddrW-1:0] addr_accum;
    logic             error_skip;
  } parse_state_t;

  typedef struct packed {
    logic [AddrW-1:0] prefix_addr;
    logic [LenW-1:0]  prefix_length;
    status_t          status;
    logic             field_end;
  } result_t;

  localparam parse_state_t StateReset = '{
    awaiting_length: 1'b1,
    held_length:     '0,
    bytes_left:      '0,
    addr_accum:      '0,
    error_skip:      1'b0
  };

endpackage

/* hdl/nlp_step.sv */
// ----------------------------------------------------------------------------
// nlp_step
// Next-state and result logic for one word of the prefix list field.
// ----------------------------------------------------------------------------
module nlp_step (
  input  nlp_pkg::parse_state_t          cur_state,
  input  logic [nlp_pkg::ByteW-1:0]      byte_value,
  input  logic                           last_byte,
  output nlp_pkg::parse_state_t          nxt_state,
  output logic                           emit,
  output nlp_pkg::result_t               result
);

  logic [nlp_pkg::ByteW:0]    len_plus;
  logic [nlp_pkg::ByteW:0]    byte_plus;
  logic [nlp_pkg::LeftW-1:0]  total;
  logic [nlp_pkg::LeftW-1:0]  first_left;
  logic [nlp_pkg::LeftW-1:0]  done_cnt;
  logic [1:0]                 idx;
  logic [nlp_pkg::AddrW-1:0]  accum_new;
  logic [nlp_pkg::LeftW-1:0]  left_new;
  logic [nlp_pkg::AddrW-1:0]  mask;

  assign len_plus   = {3'b000, cur_state.held_length} + nlp_pkg::RoundUpBits;
  assign total      = len_plus[5:3];
  assign byte_plus  = {1'b0, byte_value} + nlp_pkg::RoundUpBits;
  assign first_left = byte_plus[5:3];
  assign done_cnt   = total - cur_state.bytes_left;
  assign idx        = done_cnt[1:0];
  // octet position from the top: shift by (3 - idx) bytes
  assign accum_new  = cur_state.addr_accum |
                      ({24'd0, byte_value} << {~idx, 3'b000});
  assign left_new   = cur_state.bytes_left - 3'd1;
  assign mask       = ~({nlp_pkg::AddrW{1'b1}} >> cur_state.held_length);

  always_comb begin
    nxt_state            = cur_state;
    emit                 = 1'b0;
    result.prefix_addr   = '0;
    result.prefix_length = '0;
    result.status        = nlp_pkg::STATUS_OK;
    result.field_end     = last_byte;

    if (cur_state.error_skip) begin
      if (last_byte) begin
        nxt_state = nlp_pkg::StateReset;
      end
    end else if (cur_state.awaiting_length) begin
      if (byte_value > nlp_pkg::MaxPrefixBits) begin
        emit          = 1'b1;
        result.status = nlp_pkg::STATUS_BAD_LENGTH;
        if (last_byte) begin
          nxt_state = nlp_pkg::StateReset;
        end else begin
          nxt_state.error_skip = 1'b1;
        end
      end else begin
        nxt_state.held_length = byte_value[nlp_pkg::LenW-1:0];
        nxt_state.addr_accum  = '0;
        nxt_state.bytes_left  = first_left;
        if (first_left == '0) begin
          emit = 1'b1;
          if (last_byte) begin
            nxt_state = nlp_pkg::StateReset;
          end
        end else if (last_byte) begin
          nxt_state     = nlp_pkg::StateReset;
          emit          = 1'b1;
          result.status = nlp_pkg::STATUS_LEFTOVER;
        end else begin
          nxt_state.awaiting_length = 1'b0;
        end
      end
    end else begin
      if (left_new == '0) begin
        emit                 = 1'b1;
        result.prefix_addr   = accum_new & mask;
        result.prefix_length = cur_state.held_length;
        nxt_state            = nlp_pkg::StateReset;
      end else if (last_byte) begin
        nxt_state     = nlp_pkg::StateReset;
        emit          = 1'b1;
        result.status = nlp_pkg::STATUS_LEFTOVER;
      end else begin
        nxt_state.addr_accum = accum_new;
        nxt_state.bytes_left = left_new;
      end
    end
  end

endmodule

/* hdl/nlri_prefix_list_parser.sv */
// ----------------------------------------------------------------------------
// nlri_prefix_list_parser
// Decodes a BGP withdrawn-routes or NLRI field into IPv4 prefixes.
// ----------------------------------------------------------------------------
// The in_ channel carries the field one byte per word, with in_last_byte set
// on the final byte. Each entry is a length byte followed by its address
// bytes. The out_ channel gives one word per completed entry (host bits
// cleared), or an error word: status 1 for a length above 32, status 2 when
// the field ends inside an entry. After a bad length the rest of the field is
// dropped silently. out_field_end marks a word caused by the final byte.
// Both channels are valid/ready. A word is taken into an input register,
// decoded by one short stage of logic, and its result lands in an output
// register. Throughput is one word per cycle unless a word that yields a
// result waits on a stalled output register; the parser state register
// updates once per word. When out_ready is low with a word in the output
// register, that register holds and in_ready drops only once the input
// register holds a word that yields a result. Synchronous reset puts the
// parser at the start of a field and empties both registers.
// ----------------------------------------------------------------------------
module nlri_prefix_list_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nlp_pkg::ByteW-1:0]       in_byte_value,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nlp_pkg::AddrW-1:0]       out_prefix_addr,
  output logic [nlp_pkg::LenW-1:0]        out_prefix_length,
  output logic [nlp_pkg::StatusW-1:0]     out_status,
  output logic                            out_field_end
);

  logic                         s1_valid_r;
  logic [nlp_pkg::ByteW-1:0]    s1_byte_r;
  logic                         s1_last_r;
  nlp_pkg::parse_state_t        state_r;
  nlp_pkg::parse_state_t        state_nxt;
  logic                         out_valid_r;
  nlp_pkg::result_t             out_result_r;
  nlp_pkg::result_t             result_nxt;
  logic                         emit;
  logic                         out_free;
  logic                         s1_go;

  nlp_step u_step (
    .cur_state  (state_r),
    .byte_value (s1_byte_r),
    .last_byte  (s1_last_r),
    .nxt_state  (state_nxt),
    .emit       (emit),
    .result     (result_nxt)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= nlp_pkg::StateReset;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_go && emit;
      end
    end
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
    end
    if (out_free && s1_go && emit) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_prefix_addr   = out_result_r.prefix_addr;
  assign out_prefix_length = out_result_r.prefix_length;
  assign out_status        = out_result_r.status;
  assign out_field_end     = out_result_r.field_end;

endmodule

/* hdl/nlp_checker.sv */
// ----------------------------------------------------------------------------
// nlp_checker
// Port-level checks on the result words of the prefix list parser.
// ----------------------------------------------------------------------------
module nlp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [nlp_pkg::AddrW-1:0]       out_prefix_addr,
  input logic [nlp_pkg::LenW-1:0]        out_prefix_length,
  input logic [nlp_pkg::StatusW-1:0]     out_status,
  input logic                            out_field_end
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prefix_addr) &&
      $stable(out_prefix_length) && $stable(out_status) && $stable(out_field_end))
    else $error("stalled result word changed");

  // good prefix has legal length and no host bits
  a_host_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == nlp_pkg::STATUS_OK |->
      out_prefix_length <= 6'd32 &&
      (out_prefix_addr & ({nlp_pkg::AddrW{1'b1}} >> out_prefix_length)) == '0)
    else $error("prefix with bad length or host bits set");

  // error words carry no prefix
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == nlp_pkg::STATUS_BAD_LENGTH ||
      out_status == nlp_pkg::STATUS_LEFTOVER) |->
      out_prefix_addr == '0 && out_prefix_length == '0)
    else $error("error word carries a prefix");

  // leftover bytes only reported at field end
  a_leftover_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == nlp_pkg::STATUS_LEFTOVER |-> out_field_end)
    else $error("leftover status without field end");

  // no undefined status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == nlp_pkg::STATUS_OK ||
      out_status == nlp_pkg::STATUS_BAD_LENGTH ||
      out_status == nlp_pkg::STATUS_LEFTOVER)
    else $error("undefined status code");

endmodule

bind nlri_prefix_list_parser nlp_checker u_nlp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_prefix_addr   (out_prefix_addr),
  .out_prefix_length (out_prefix_length),
  .out_status        (out_status),
  .out_field_end     (out_field_end)
);
